### design/sem_pkg.sv
// Shared types and constants for the Sobel edge magnitude stream unit.
`default_nettype none

package sem_pkg;

    typedef struct packed {
        logic emit;
        logic last;
    } sem_flags_t;

    localparam int PIXEL_W       = 8;
    localparam int MIN_DIM       = 3;
    localparam int SQRT_STEPS    = 8;

    localparam logic [11:0] LINE_WIDTH_RESET   = 12'd640;
    localparam logic [15:0] FRAME_HEIGHT_RESET = 16'd480;
    localparam logic [7:0]  MAG_MAX            = 8'd255;

    localparam logic ADDR_LINE_WIDTH   = 1'b0;
    localparam logic ADDR_FRAME_HEIGHT = 1'b1;

endpackage

`default_nettype wire

### design/sem_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module sem_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

### design/sem_front.sv
// Input front end: column and row tracking and classification of each pixel word.
`default_nettype none

module sem_front import sem_pkg::*; #(
    parameter int MAX_LINE_WIDTH = 2048,
    localparam int CW = $clog2(MAX_LINE_WIDTH)
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic [11:0]        line_width,
    input  wire logic [15:0]        frame_height,
    input  wire logic               s_valid,
    input  wire logic [PIXEL_W-1:0] s_pixel,
    output logic                    s_ready,
    input  wire logic               queue_full,
    output logic                    push,
    output logic      [PIXEL_W-1:0] push_pixel,
    output logic      [CW-1:0]      push_col,
    output sem_flags_t              push_flags
);

    localparam int WW = (CW + 1 > 12) ? CW + 1 : 12;

    logic [CW-1:0] col_reg, col_next;
    logic [15:0]   row_reg, row_next;
    logic [WW-1:0] w_raw, w_max, w_eff, col_inc;
    logic [15:0]   h_eff;
    logic [16:0]   row_inc;
    logic          last_col, last_row, accept;

    assign w_raw = WW'(line_width);
    assign w_max = WW'(MAX_LINE_WIDTH);

    always_comb begin
        priority if (w_raw < WW'(MIN_DIM)) begin
            w_eff = WW'(MIN_DIM);
        end else if (w_raw > w_max) begin
            w_eff = w_max;
        end else begin
            w_eff = w_raw;
        end
    end

    assign h_eff    = (frame_height < 16'(MIN_DIM)) ? 16'(MIN_DIM) : frame_height;
    assign col_inc  = WW'(col_reg) + WW'(1);
    assign row_inc  = {1'b0, row_reg} + 17'd1;
    assign last_col = (col_inc >= w_eff);
    assign last_row = (row_inc >= {1'b0, h_eff});

    assign s_ready = !queue_full;
    assign accept  = s_valid && s_ready;

    assign push            = accept;
    assign push_pixel      = s_pixel;
    assign push_col        = col_reg;
    assign push_flags.emit = (row_reg >= 16'd2) && (col_reg >= CW'(2));
    assign push_flags.last = last_col && last_row;

    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (accept) begin
            if (last_col) begin
                col_next = '0;
                row_next = last_row ? 16'd0 : row_inc[15:0];
            end else begin
                col_next = col_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

`default_nettype wire

### design/sem_queue.sv
// Short word queue between the front end and the compute back end.
`default_nettype none

module sem_queue #(
    parameter int WIDTH = 21,
    parameter int DEPTH = 4,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    input  wire logic             pop,
    output logic      [WIDTH-1:0] head_data,
    output logic                  full,
    output logic                  empty
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [AW:0]      count_reg;

    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
        return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
    endfunction

    assign full      = (count_reg == (AW + 1)'(DEPTH));
    assign empty     = (count_reg == '0);
    assign head_data = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (pop) begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            unique case ({push, pop})
                2'b10:   count_reg <= count_reg + (AW + 1)'(1);
                2'b01:   count_reg <= count_reg - (AW + 1)'(1);
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

`default_nettype wire

### design/sem_back.sv
// Compute back end: row stores, 3x3 window, Sobel gradients, squares and square root.
`default_nettype none

module sem_back import sem_pkg::*; #(
    parameter int MAX_LINE_WIDTH = 2048,
    localparam int CW = $clog2(MAX_LINE_WIDTH)
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               q_empty,
    input  wire logic [PIXEL_W-1:0] q_pixel,
    input  wire logic [CW-1:0]      q_col,
    input  wire sem_flags_t         q_flags,
    output logic                    q_pop,
    input  wire logic               m_ready,
    output logic                    m_valid,
    output logic      [7:0]         m_edge_magnitude,
    output logic                    m_last_of_frame
);

    logic adv;

    // window stage
    logic               b_valid_reg;
    logic [PIXEL_W-1:0] b_pixel_reg;
    logic [CW-1:0]      b_col_reg;
    sem_flags_t         b_flags_reg;
    logic [PIXEL_W-1:0] up_rd, mid_rd;
    logic [PIXEL_W-1:0] win_reg   [9];
    logic [PIXEL_W-1:0] win_shift [9];
    logic signed [11:0] p [9];
    logic signed [11:0] gx, gy;

    // gradient stage
    logic               c_valid_reg, c_last_reg;
    logic signed [11:0] gx_reg, gy_reg;
    logic [9:0]         ax, ay;

    // square stage
    logic               d_valid_reg, d_last_reg;
    logic [19:0]        sqx_reg, sqy_reg;
    logic [20:0]        sum;

    // square root stages
    logic               s_valid_reg [SQRT_STEPS+1];
    logic               s_last_reg  [SQRT_STEPS+1];
    logic               s_sat_reg   [SQRT_STEPS+1];
    logic [15:0]        s_val_reg   [SQRT_STEPS+1];
    logic [7:0]         s_root_reg  [SQRT_STEPS+1];

    logic               m_valid_reg, m_last_reg;
    logic [7:0]         m_mag_reg;

    assign adv   = !m_valid_reg || m_ready;
    assign q_pop = adv && !q_empty;

    sem_ram #(.WIDTH(PIXEL_W), .DEPTH(MAX_LINE_WIDTH)) u_upper (
        .aclk  (aclk),
        .we    (adv && b_valid_reg),
        .waddr (b_col_reg),
        .wdata (mid_rd),
        .re    (q_pop),
        .raddr (q_col),
        .rdata (up_rd)
    );

    sem_ram #(.WIDTH(PIXEL_W), .DEPTH(MAX_LINE_WIDTH)) u_middle (
        .aclk  (aclk),
        .we    (adv && b_valid_reg),
        .waddr (b_col_reg),
        .wdata (b_pixel_reg),
        .re    (q_pop),
        .raddr (q_col),
        .rdata (mid_rd)
    );

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            win_shift[i*3]   = win_reg[i*3+1];
            win_shift[i*3+1] = win_reg[i*3+2];
        end
        win_shift[2] = up_rd;
        win_shift[5] = mid_rd;
        win_shift[8] = b_pixel_reg;
        for (int k = 0; k < 9; k++) begin
            p[k] = signed'({4'b0000, win_shift[k]});
        end
        gx = (p[2] - p[0]) + ((p[5] - p[3]) <<< 1) + (p[8] - p[6]);
        gy = (p[6] + (p[7] <<< 1) + p[8]) - (p[0] + (p[1] <<< 1) + p[2]);
    end

    assign ax  = gx_reg[11] ? 10'(-gx_reg) : 10'(gx_reg);
    assign ay  = gy_reg[11] ? 10'(-gy_reg) : 10'(gy_reg);
    assign sum = {1'b0, sqx_reg} + {1'b0, sqy_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg    <= 1'b0;
            c_valid_reg    <= 1'b0;
            d_valid_reg    <= 1'b0;
            s_valid_reg[0] <= 1'b0;
            m_valid_reg    <= 1'b0;
            for (int k = 0; k < 9; k++) begin
                win_reg[k] <= '0;
            end
        end else if (adv) begin
            b_valid_reg    <= q_pop;
            c_valid_reg    <= b_valid_reg && b_flags_reg.emit;
            d_valid_reg    <= c_valid_reg;
            s_valid_reg[0] <= d_valid_reg;
            m_valid_reg    <= s_valid_reg[SQRT_STEPS];
            if (b_valid_reg) begin
                win_reg <= win_shift;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            if (q_pop) begin
                b_pixel_reg <= q_pixel;
                b_col_reg   <= q_col;
                b_flags_reg <= q_flags;
            end
            c_last_reg   <= b_flags_reg.last;
            gx_reg       <= gx;
            gy_reg       <= gy;
            d_last_reg   <= c_last_reg;
            sqx_reg      <= ax * ax;
            sqy_reg      <= ay * ay;
            s_last_reg[0] <= d_last_reg;
            s_sat_reg[0]  <= |sum[20:16];
            s_val_reg[0]  <= sum[15:0];
            s_root_reg[0] <= '0;
            m_last_reg   <= s_last_reg[SQRT_STEPS];
            m_mag_reg    <= s_sat_reg[SQRT_STEPS] ? MAG_MAX : s_root_reg[SQRT_STEPS];
        end
    end

    for (genvar k = 1; k <= SQRT_STEPS; k++) begin : g_sqrt
        logic [7:0]  trial;
        logic [15:0] trial_sq;

        assign trial    = s_root_reg[k-1] | (8'd1 << (SQRT_STEPS - k));
        assign trial_sq = trial * trial;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                s_valid_reg[k] <= 1'b0;
            end else if (adv) begin
                s_valid_reg[k] <= s_valid_reg[k-1];
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                s_last_reg[k] <= s_last_reg[k-1];
                s_sat_reg[k]  <= s_sat_reg[k-1];
                s_val_reg[k]  <= s_val_reg[k-1];
                s_root_reg[k] <= (trial_sq <= s_val_reg[k-1]) ? trial : s_root_reg[k-1];
            end
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_edge_magnitude = m_mag_reg;
    assign m_last_of_frame  = m_last_reg;

endmodule

`default_nettype wire

### design/sobel_edge_magnitude_stream_unit.sv
// Top level of the Sobel edge magnitude stream unit with its APB register port.
// Throughput: one pixel word per cycle unless m_ready stalls the output, set by the one read
//   and one write per cycle that each row store RAM offers; only interior pixels produce result words.
// Reset (aresetn low at a clock edge): counters, queue and pipeline valids clear,
//   line_width returns to 640 and frame_height to 480; row store contents are kept.
`default_nettype none

module sobel_edge_magnitude_stream_unit import sem_pkg::*; #(
    parameter int MAX_LINE_WIDTH = 2048,
    localparam int CW = $clog2(MAX_LINE_WIDTH)
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [2:2]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic      [31:0]        prdata,
    output logic                    pready,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [PIXEL_W-1:0] s_pixel,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic      [7:0]         m_edge_magnitude,
    output logic                    m_last_of_frame
);

    localparam int QW = PIXEL_W + CW + $bits(sem_flags_t);

    logic [11:0] line_width_reg, line_width_next;
    logic [15:0] frame_height_reg, frame_height_next;
    logic        cfg_write;

    logic               queue_full, queue_empty, push, pop;
    logic [PIXEL_W-1:0] push_pixel, q_pixel;
    logic [CW-1:0]      push_col, q_col;
    sem_flags_t         push_flags, q_flags;
    logic [QW-1:0]      q_head;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb begin
        line_width_next   = line_width_reg;
        frame_height_next = frame_height_reg;
        if (cfg_write) begin
            unique case (paddr[2])
                ADDR_LINE_WIDTH:   line_width_next   = pwdata[11:0];
                ADDR_FRAME_HEIGHT: frame_height_next = pwdata[15:0];
                default:           line_width_next   = line_width_reg;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            ADDR_LINE_WIDTH:   prdata = {20'd0, line_width_reg};
            ADDR_FRAME_HEIGHT: prdata = {16'd0, frame_height_reg};
            default:           prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_width_reg   <= LINE_WIDTH_RESET;
            frame_height_reg <= FRAME_HEIGHT_RESET;
        end else begin
            line_width_reg   <= line_width_next;
            frame_height_reg <= frame_height_next;
        end
    end

    sem_front #(.MAX_LINE_WIDTH(MAX_LINE_WIDTH)) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .line_width   (line_width_reg),
        .frame_height (frame_height_reg),
        .s_valid      (s_valid),
        .s_pixel      (s_pixel),
        .s_ready      (s_ready),
        .queue_full   (queue_full),
        .push         (push),
        .push_pixel   (push_pixel),
        .push_col     (push_col),
        .push_flags   (push_flags)
    );

    sem_queue #(.WIDTH(QW), .DEPTH(4)) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data ({push_pixel, push_col, push_flags}),
        .pop       (pop),
        .head_data (q_head),
        .full      (queue_full),
        .empty     (queue_empty)
    );

    assign {q_pixel, q_col, q_flags} = q_head;

    sem_back #(.MAX_LINE_WIDTH(MAX_LINE_WIDTH)) u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .q_empty          (queue_empty),
        .q_pixel          (q_pixel),
        .q_col            (q_col),
        .q_flags          (q_flags),
        .q_pop            (pop),
        .m_ready          (m_ready),
        .m_valid          (m_valid),
        .m_edge_magnitude (m_edge_magnitude),
        .m_last_of_frame  (m_last_of_frame)
    );

endmodule

`default_nettype wire

### design/sem_checker.sv
// Port-level assertions for the Sobel edge magnitude stream unit, bound to the top level.
`default_nettype none

module sem_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        psel,
    input wire logic        penable,
    input wire logic        pwrite,
    input wire logic [2:2]  paddr,
    input wire logic [31:0] pwdata,
    input wire logic [31:0] prdata,
    input wire logic        pready,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [7:0]  m_edge_magnitude,
    input wire logic        m_last_of_frame
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result word dropped while stalled");

    a_out_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_edge_magnitude) && $stable(m_last_of_frame))
        else $error("result word changed while stalled");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_width_readback: assert property (@(posedge aclk) disable iff (!aresetn)
        (psel && penable && pwrite && pready && !paddr[2]) ##1 !paddr[2]
        |-> prdata[11:0] == $past(pwdata[11:0]))
        else $error("line width readback mismatch");

    a_height_readback: assert property (@(posedge aclk) disable iff (!aresetn)
        (psel && penable && pwrite && pready && paddr[2]) ##1 paddr[2]
        |-> prdata[15:0] == $past(pwdata[15:0]))
        else $error("frame height readback mismatch");

endmodule

bind sobel_edge_magnitude_stream_unit sem_checker u_sem_checker (.*);

`default_nettype wire

### test/tb_top.sv
// Self-checking testbench for the Sobel edge magnitude stream unit.
`timescale 1ns / 1ps

module tb_top;
    import sem_pkg::*;

    localparam int LINE_MAX      = 2048;
    localparam int WIDE_ROW      = 128;
    localparam int RANDOM_WORDS  = 780;
    localparam int SETTLE_CYCLES = 20;
    localparam int STALL_LIMIT   = 2000;
    localparam int PRINT_CAP     = 100;

    typedef struct packed {
        logic [7:0] magnitude;
        logic       last;
    } edge_word_t;

    typedef enum int {
        TEXTURE_UNIFORM,
        TEXTURE_LOW_CONTRAST,
        TEXTURE_BINARY,
        TEXTURE_RAMP
    } texture_t;

    logic                aclk    = 1'b0;
    logic                aresetn = 1'b0;
    logic                psel    = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite  = 1'b0;
    logic [2:2]          paddr   = ADDR_LINE_WIDTH;
    logic [31:0]         pwdata  = '0;
    logic [31:0]         prdata;
    logic                pready;
    logic                s_valid = 1'b0;
    logic                s_ready;
    logic [PIXEL_W-1:0]  s_pixel = '0;
    logic                m_valid;
    logic                m_ready = 1'b1;
    logic [7:0]          m_edge_magnitude;
    logic                m_last_of_frame;

    // predictor state
    logic [11:0]         cfg_line_width   = LINE_WIDTH_RESET;
    logic [15:0]         cfg_frame_height = FRAME_HEIGHT_RESET;
    logic [7:0]          upper_row [LINE_MAX];
    logic [7:0]          middle_row [LINE_MAX];
    logic [7:0]          win [9];
    logic [10:0]         col_pos;
    logic [15:0]         row_pos;

    logic [PIXEL_W-1:0]  pixel_queue [$];
    edge_word_t          expected_edges [$];
    edge_word_t          head;

    int                  feed_gap, feed_burst, drain_gap, drain_burst, sink_pause;
    int                  stall_cycles;
    int                  mismatches, pixels_taken, edges_seen, frames_closed, cfg_writes;

    sobel_edge_magnitude_stream_unit #(
        .MAX_LINE_WIDTH(LINE_MAX)
    ) dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_pixel          (s_pixel),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_edge_magnitude (m_edge_magnitude),
        .m_last_of_frame  (m_last_of_frame)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    function automatic int unsigned clamp_width(logic [11:0] v);
        if (v < MIN_DIM) return MIN_DIM;
        if (v > LINE_MAX) return LINE_MAX;
        return v;
    endfunction

    function automatic int unsigned clamp_height(logic [15:0] v);
        return (v < MIN_DIM) ? MIN_DIM : v;
    endfunction

    function automatic logic [7:0] root_clamped(int unsigned sum);
        int unsigned root;
        int unsigned trial;
        if (sum >= 65536) return MAG_MAX;
        root = 0;
        for (int b = 7; b >= 0; b--) begin
            trial = root | (1 << b);
            if (trial * trial <= sum) root = trial;
        end
        return root[7:0];
    endfunction

    function automatic void sobel_predict(logic [7:0] px);
        int unsigned w, h, c, r;
        bit          end_col, end_row;
        int          gx, gy;
        edge_word_t  word;
        w = clamp_width(cfg_line_width);
        h = clamp_height(cfg_frame_height);
        c = col_pos;
        r = row_pos;
        end_col = (c + 1 >= w);
        end_row = (r + 1 >= h);
        for (int i = 0; i < 3; i++) begin
            win[3*i]   = win[3*i+1];
            win[3*i+1] = win[3*i+2];
        end
        win[2] = upper_row[c];
        win[5] = middle_row[c];
        win[8] = px;
        upper_row[c]  = middle_row[c];
        middle_row[c] = px;
        if (r >= 2 && c >= 2) begin
            gx = (int'(win[2]) - int'(win[0])) + 2 * (int'(win[5]) - int'(win[3]))
               + (int'(win[8]) - int'(win[6]));
            gy = (int'(win[6]) + 2 * int'(win[7]) + int'(win[8]))
               - (int'(win[0]) + 2 * int'(win[1]) + int'(win[2]));
            word.magnitude = root_clamped(gx * gx + gy * gy);
            word.last      = end_col && end_row;
            expected_edges.push_back(word);
        end
        if (end_col) begin
            col_pos = '0;
            row_pos = end_row ? 16'd0 : 16'(r + 1);
        end else begin
            col_pos = 11'(c + 1);
        end
    endfunction

    task automatic flag(string msg);
        if (mismatches < PRINT_CAP) $display("%0t ns: %s", $time, msg);
        mismatches++;
    endtask

    // pixel source
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid     <= 1'b0;
            feed_gap    <= 0;
            feed_burst  <= 0;
            col_pos      = '0;
            row_pos      = '0;
            foreach (win[i]) win[i] = '0;
            cfg_line_width   = LINE_WIDTH_RESET;
            cfg_frame_height = FRAME_HEIGHT_RESET;
        end else begin
            if (s_valid && s_ready) begin
                sobel_predict(s_pixel);
                pixels_taken++;
            end
            if (!s_valid || s_ready) begin
                if (feed_gap != 0) begin
                    feed_gap <= feed_gap - 1;
                    s_valid  <= 1'b0;
                end else if (pixel_queue.size() != 0) begin
                    s_pixel <= pixel_queue.pop_front();
                    s_valid <= 1'b1;
                    if (feed_burst != 0) begin
                        feed_burst <= feed_burst - 1;
                    end else begin
                        feed_gap <= $urandom_range(0, 3);
                        if ($urandom_range(0, 15) == 0) feed_burst <= $urandom_range(8, 40);
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // edge word sink and compare
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready     <= 1'b1;
            drain_gap   <= 0;
            drain_burst <= 0;
        end else if (m_valid && m_ready) begin
            if (expected_edges.size() == 0) begin
                flag($sformatf("edge word with nothing expected: magnitude %0d last %0d",
                               m_edge_magnitude, m_last_of_frame));
            end else begin
                head = expected_edges.pop_front();
                if (m_edge_magnitude !== head.magnitude)
                    flag($sformatf("edge_magnitude expected %0d actual %0d",
                                   head.magnitude, m_edge_magnitude));
                if (m_last_of_frame !== head.last)
                    flag($sformatf("last_of_frame expected %0d actual %0d",
                                   head.last, m_last_of_frame));
                if (head.last) frames_closed++;
            end
            edges_seen++;
            if (drain_burst != 0) begin
                drain_burst <= drain_burst - 1;
            end else begin
                sink_pause = $urandom_range(0, 3);
                m_ready   <= (sink_pause == 0);
                drain_gap <= sink_pause;
                if ($urandom_range(0, 15) == 0) drain_burst <= $urandom_range(8, 40);
            end
        end else if (drain_gap != 0) begin
            drain_gap <= drain_gap - 1;
            if (drain_gap == 1) m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        wait (stall_cycles >= STALL_LIMIT);
        $display("%0t ns: no word moved for %0d cycles", $time, STALL_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    task automatic apb_transfer(input logic wr, input logic [2:2] addr,
                                input logic [31:0] wdata, output logic [31:0] rdata);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= wdata;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        rdata    = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic reg_check(logic [2:2] addr, logic [31:0] want);
        logic [31:0] got;
        apb_transfer(1'b0, addr, '0, got);
        if (got !== want)
            flag($sformatf("register %0d readback expected %0d actual %0d", addr, want, got));
    endtask

    task automatic cfg_write(logic [2:2] addr, logic [31:0] wdata);
        logic [31:0] unused;
        apb_transfer(1'b1, addr, wdata, unused);
        if (addr == ADDR_LINE_WIDTH) begin
            cfg_line_width = wdata[11:0];
            reg_check(addr, {20'd0, wdata[11:0]});
        end else begin
            cfg_frame_height = wdata[15:0];
            reg_check(addr, {16'd0, wdata[15:0]});
        end
        cfg_writes++;
    endtask

    task automatic feed_pixels(int unsigned count, texture_t texture);
        logic [7:0] base;
        logic [7:0] slope;
        logic [7:0] px;
        base  = $urandom;
        slope = $urandom_range(0, 24);
        for (int unsigned i = 0; i < count; i++) begin
            case (texture)
                TEXTURE_UNIFORM:      px = $urandom;
                TEXTURE_LOW_CONTRAST: px = 8'(base + $urandom_range(0, 15));
                TEXTURE_BINARY:       px = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                default:              px = 8'(base + slope * i + $urandom_range(0, 7));
            endcase
            pixel_queue.push_back(px);
        end
    endtask

    task automatic settle();
        do @(negedge aclk);
        while (pixel_queue.size() != 0 || s_valid || expected_edges.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    initial begin : stimulus
        logic [11:0] new_width;
        logic [15:0] new_height;
        logic [31:0] wdata;
        int unsigned words, random_words, phase, pick, w, h;

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        reg_check(ADDR_LINE_WIDTH, {20'd0, LINE_WIDTH_RESET});
        reg_check(ADDR_FRAME_HEIGHT, {16'd0, FRAME_HEIGHT_RESET});

        // step edge at full contrast, dimensions below minimum
        cfg_write(ADDR_LINE_WIDTH, 32'd2);
        cfg_write(ADDR_FRAME_HEIGHT, 32'd0);
        for (int i = 0; i < 9; i++) pixel_queue.push_back((i % 3 == 2) ? 8'hFF : 8'h00);
        settle();
        // flat white field
        cfg_write(ADDR_LINE_WIDTH, 32'd1);
        cfg_write(ADDR_FRAME_HEIGHT, 32'd2);
        for (int i = 0; i < 9; i++) pixel_queue.push_back(8'hFF);
        settle();
        // weak edge below saturation
        cfg_write(ADDR_LINE_WIDTH, 32'd3);
        cfg_write(ADDR_FRAME_HEIGHT, 32'd3);
        for (int i = 0; i < 9; i++) pixel_queue.push_back((i % 3 == 2) ? 8'd3 : 8'd0);
        settle();

        random_words = 0;
        phase = 0;
        while (random_words < RANDOM_WORDS) begin
            if (phase < 2 || $urandom_range(0, 3) != 0) begin
                case ($urandom_range(0, 7))
                    0:       new_width = $urandom_range(0, 2);
                    1:       new_width = $urandom_range(13, 40);
                    default: new_width = $urandom_range(3, 12);
                endcase
                // grow the row only at a frame start
                if ((col_pos != 0 || row_pos != 0)
                        && clamp_width(new_width) > clamp_width(cfg_line_width))
                    new_width = $urandom_range(0, clamp_width(cfg_line_width));
                case ($urandom_range(0, 7))
                    0:       new_height = $urandom_range(0, 2);
                    1:       new_height = $urandom_range(7, 20);
                    default: new_height = $urandom_range(3, 6);
                endcase
                if (phase == 0) new_height = 16'hFFFF;
                else if (phase == 1) new_height = $urandom_range(0, 2);
                pick = (phase < 2) ? 2 : $urandom_range(0, 3);
                if (pick != 1) begin
                    wdata = $urandom;
                    wdata[11:0] = new_width;
                    if ($urandom_range(0, 3) != 0) wdata[31:12] = '0;
                    cfg_write(ADDR_LINE_WIDTH, wdata);
                end
                if (pick != 0) begin
                    wdata = $urandom;
                    wdata[15:0] = new_height;
                    if ($urandom_range(0, 3) != 0) wdata[31:16] = '0;
                    cfg_write(ADDR_FRAME_HEIGHT, wdata);
                end
            end
            words = $urandom_range(1, 120);
            feed_pixels(words, texture_t'($urandom_range(0, 3)));
            random_words += words;
            settle();
            phase++;
        end

        // close the open frame, then one frame at a wide row
        w = clamp_width(cfg_line_width);
        h = clamp_height(cfg_frame_height);
        if (col_pos != 0 || row_pos != 0) begin
            words = (col_pos + 1 >= w) ? 1 : w - col_pos;
            if (row_pos + 1 < h) words += (h - row_pos - 1) * w;
            feed_pixels(words, TEXTURE_UNIFORM);
            settle();
        end
        wdata = $urandom;
        wdata[11:0] = 12'(WIDE_ROW);
        cfg_write(ADDR_LINE_WIDTH, wdata);
        cfg_write(ADDR_FRAME_HEIGHT, 32'd3);
        feed_pixels(3 * WIDE_ROW, texture_t'($urandom_range(0, 3)));
        settle();

        $display("Run moved %0d pixel words and %0d edge words over %0d register writes,",
                 pixels_taken, edges_seen, cfg_writes);
        $display("closing %0d frames, with %0d mismatches.", frames_closed, mismatches);
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
